// ----- rtl/pso_pkg.sv -----
// ----------------------------------------------------------------------------
// pso_pkg: shared types and constants for the particle update pipeline
// Defines the request and response transaction structs and register indexes.
// ----------------------------------------------------------------------------
package pso_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int DW = DATA_WIDTH;

   localparam logic [16:0] WEIGHT_FLOOR = 17'd26214;

   localparam logic [2:0] REG_WEIGHT_MODE = 3'd0;
   localparam logic [2:0] REG_INERTIA     = 3'd1;
   localparam logic [2:0] REG_MAX_VEL     = 3'd2;
   localparam logic [2:0] REG_BOUNDS_EN   = 3'd3;
   localparam logic [2:0] REG_LOWER       = 3'd4;
   localparam logic [2:0] REG_UPPER       = 3'd5;
   localparam logic [2:0] REG_MAX_GEN     = 3'd6;

   typedef struct packed {
      logic signed [DW-1:0] position;
      logic signed [DW-1:0] velocity;
      logic signed [DW-1:0] own_best_position;
      logic signed [DW-1:0] swarm_best_position;
      logic [15:0]          rand_a;
      logic [15:0]          rand_b;
      logic [15:0]          generation;
      logic signed [DW-1:0] fitness;
      logic signed [DW-1:0] own_best_fitness;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] new_velocity;
      logic signed [DW-1:0] new_position;
      logic signed [DW-1:0] new_own_best_position;
      logic signed [DW-1:0] new_own_best_fitness;
      logic                 improved;
   } rsp_type;

endpackage

// ----- rtl/pso_particle_update.sv -----
// ----------------------------------------------------------------------------
// pso_particle_update: particle swarm velocity and position update
// Updates one coordinate of one particle per transaction, fully pipelined.
// ----------------------------------------------------------------------------
// One transaction may be issued on every clock cycle: busy is never raised,
// and each result appears on the rsp_ ports, marked by rsp_valid, from the
// result register of the last stage. The pipe holds the weight divider, a
// restoring divider with two quotient bits per pipeline stage (three in the
// first) over sixteen stages, preceded by the input stage and followed by
// the multiply, sum, clamp and bounds stages. The receiver cannot stall the
// block, so no back pressure exists anywhere in the pipe. Configuration may
// be written whenever the pipe is empty; it is read directly by the stages.
module pso_particle_update (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  pso_pkg::req_type     req_data,
   output logic                 rsp_valid,
   output pso_pkg::rsp_type     rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata
);
   import pso_pkg::*;

   localparam int NDIV = 16;
   localparam int DW1  = DATA_WIDTH + 1;
   localparam int PW   = DATA_WIDTH + 19;
   localparam int AW   = DATA_WIDTH + 20;

   // Configuration registers.
   logic                  weight_mode_ff;
   logic [16:0]           inertia_ff;
   logic [30:0]           max_vel_ff;
   logic                  bounds_en_ff;
   logic signed [DW-1:0]  lower_ff, upper_ff;
   logic [15:0]           max_gen_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_mode_ff <= 1'b0;
         inertia_ff     <= 17'd52429;
         max_vel_ff     <= 31'd655360;
         bounds_en_ff   <= 1'b0;
         lower_ff       <= -32'sd655360;
         upper_ff       <= 32'sd655360;
         max_gen_ff     <= 16'd1000;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_WEIGHT_MODE: weight_mode_ff <= csr_wdata[0];
            REG_INERTIA:     inertia_ff     <= csr_wdata[16:0];
            REG_MAX_VEL:     max_vel_ff     <= csr_wdata[30:0];
            REG_BOUNDS_EN:   bounds_en_ff   <= csr_wdata[0];
            REG_LOWER:       lower_ff       <= csr_wdata;
            REG_UPPER:       upper_ff       <= csr_wdata;
            REG_MAX_GEN:     max_gen_ff     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Pipe registers of the input stage (index 0) and the divider stages.
   logic [NDIV:0]          dv_valid_ff;
   req_type                dv_req_ff   [NDIV+1];
   logic                   dv_better_ff[NDIV+1];
   logic signed [DW1-1:0]  dv_da_ff    [NDIV+1];
   logic signed [DW1-1:0]  dv_db_ff    [NDIV+1];
   logic [32:0]            dv_num_ff   [NDIV+1];
   logic [16:0]            dv_rem_ff   [NDIV+1];
   logic                   dv_neg_ff   [NDIV+1];
   logic                   dv_const_ff [NDIV+1];

   // Stage 0: personal best selection, differences, weight numerator.
   // The decay term is |d|*(M-g) (at most 17+16 bits) divided by M; the sign
   // is reapplied after the divider, giving truncation toward zero.
   logic                   better_in;
   logic signed [DW-1:0]   pbest_in;
   logic signed [17:0]     d_in;
   logic [16:0]            dmag_in;
   logic [15:0]            g_in;

   always_comb begin
      better_in = req_data.fitness < req_data.own_best_fitness;
      pbest_in  = better_in ? req_data.position : req_data.own_best_position;
      d_in      = $signed({1'b0, inertia_ff}) - $signed({1'b0, WEIGHT_FLOOR});
      dmag_in   = d_in[17] ? 17'(-d_in) : d_in[16:0];
      g_in      = (req_data.generation > max_gen_ff) ? max_gen_ff : req_data.generation;
   end

   always_ff @(posedge clock) begin
      if (reset) dv_valid_ff[0] <= 1'b0;
      else       dv_valid_ff[0] <= start;
      dv_req_ff[0]    <= req_data;
      dv_better_ff[0] <= better_in;
      dv_da_ff[0]     <= DW1'(pbest_in) - DW1'(req_data.position);
      dv_db_ff[0]     <= DW1'(req_data.swarm_best_position) - DW1'(req_data.position);
      dv_num_ff[0]    <= 33'(dmag_in) * 33'(max_gen_ff - g_in);
      dv_rem_ff[0]    <= 17'd0;
      dv_neg_ff[0]    <= d_in[17];
      dv_const_ff[0]  <= ~weight_mode_ff;
   end

   // Stages 1..NDIV: restoring division, two quotient bits per stage over
   // a 33-bit numerator (three bits in stage 1, then two in each of the rest).
   // Numerator bits are shifted out of the top; quotient bits shifted in.
   for (genvar k = 1; k <= NDIV; k++) begin : g_div
      logic [32:0] num_in;
      logic [16:0] rem_in;
      always_comb begin
         logic [17:0] r;
         logic [32:0] n;
         n = dv_num_ff[k-1];
         r = {1'b0, dv_rem_ff[k-1]};
         for (int b = 0; b < ((k == 1) ? 3 : 2); b++) begin
            r = {r[16:0], n[32]};
            n = {n[31:0], 1'b0};
            if (r >= {2'b0, max_gen_ff}) begin
               r    = r - {2'b0, max_gen_ff};
               n[0] = 1'b1;
            end
         end
         num_in = n;
         rem_in = r[16:0];
      end
      always_ff @(posedge clock) begin
         if (reset) dv_valid_ff[k] <= 1'b0;
         else       dv_valid_ff[k] <= dv_valid_ff[k-1];
         dv_req_ff[k]    <= dv_req_ff[k-1];
         dv_better_ff[k] <= dv_better_ff[k-1];
         dv_da_ff[k]     <= dv_da_ff[k-1];
         dv_db_ff[k]     <= dv_db_ff[k-1];
         dv_num_ff[k]    <= num_in;
         dv_rem_ff[k]    <= rem_in;
         dv_neg_ff[k]    <= dv_neg_ff[k-1];
         dv_const_ff[k]  <= dv_const_ff[k-1];
      end
   end

   // Stage M: weight, then the three products.
   logic signed [18:0] w_in;
   logic [16:0]        q_lo;
   always_comb begin
      // Quotient is at most |d|, so 17 bits suffice.
      q_lo = dv_num_ff[NDIV][16:0];
      if (dv_const_ff[NDIV])
         w_in = $signed({2'b0, inertia_ff});
      else if (max_gen_ff == 16'd0)
         w_in = $signed({2'b0, WEIGHT_FLOOR});
      else if (dv_neg_ff[NDIV])
         w_in = $signed({2'b0, WEIGHT_FLOOR}) - $signed({2'b0, q_lo});
      else
         w_in = $signed({2'b0, WEIGHT_FLOOR}) + $signed({2'b0, q_lo});
   end

   logic                  m_valid_ff;
   req_type               m_req_ff;
   logic                  m_better_ff;
   logic signed [PW-1:0]  m_pw_ff, m_pa_ff, m_pb_ff;

   always_ff @(posedge clock) begin
      if (reset) m_valid_ff <= 1'b0;
      else       m_valid_ff <= dv_valid_ff[NDIV];
      m_req_ff    <= dv_req_ff[NDIV];
      m_better_ff <= dv_better_ff[NDIV];
      m_pw_ff <= PW'(w_in) * PW'($signed(dv_req_ff[NDIV].velocity[DATA_WIDTH-1:0]));
      m_pa_ff <= PW'($signed({1'b0, dv_req_ff[NDIV].rand_a, 1'b0})) * PW'(dv_da_ff[NDIV]);
      m_pb_ff <= PW'($signed({1'b0, dv_req_ff[NDIV].rand_b, 1'b0})) * PW'(dv_db_ff[NDIV]);
   end

   // Stage A: exact sum and floor shift.
   logic                  a_valid_ff;
   req_type               a_req_ff;
   logic                  a_better_ff;
   logic signed [AW-17:0] a_nv_ff;

   logic signed [AW-1:0]  acc_in;
   assign acc_in = AW'(m_pw_ff) + AW'(m_pa_ff) + AW'(m_pb_ff);

   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else       a_valid_ff <= m_valid_ff;
      a_req_ff    <= m_req_ff;
      a_better_ff <= m_better_ff;
      a_nv_ff     <= acc_in[AW-1:16];
   end

   // Stage C: velocity clamp and saturation, position add.
   logic                  c_valid_ff;
   req_type               c_req_ff;
   logic                  c_better_ff;
   logic signed [DW-1:0]  c_nv_ff;
   logic signed [DW1-1:0] c_np_ff;

   logic signed [AW-16:0] vmax_s, nv_c;
   logic signed [DW-1:0]  nv_sat;
   logic signed [DW1-1:0] dmax, dmin;
   always_comb begin
      vmax_s = $signed((AW-15)'(max_vel_ff));
      nv_c   = (AW-15)'(a_nv_ff);
      if (nv_c > vmax_s)  nv_c = vmax_s;
      if (nv_c < -vmax_s) nv_c = -vmax_s;
      dmax = $signed({2'b00, {(DATA_WIDTH-1){1'b1}}});
      dmin = -dmax - DW1'(1);
      if (nv_c > (AW-15)'(dmax))      nv_sat = DW'(dmax);
      else if (nv_c < (AW-15)'(dmin)) nv_sat = DW'(dmin);
      else                            nv_sat = DW'(nv_c);
   end

   always_ff @(posedge clock) begin
      if (reset) c_valid_ff <= 1'b0;
      else       c_valid_ff <= a_valid_ff;
      c_req_ff    <= a_req_ff;
      c_better_ff <= a_better_ff;
      c_nv_ff     <= nv_sat;
      c_np_ff     <= DW1'($signed(a_req_ff.position[DATA_WIDTH-1:0]))
                   + DW1'($signed(nv_sat[DATA_WIDTH-1:0]));
   end

   // Stage O: position saturation and bounds, result register.
   logic signed [DW-1:0]  np_out;
   logic signed [DW1-1:0] pmax, pmin;
   always_comb begin
      pmax = $signed({2'b00, {(DATA_WIDTH-1){1'b1}}});
      pmin = -pmax - DW1'(1);
      if (c_np_ff > pmax)      np_out = DW'(pmax);
      else if (c_np_ff < pmin) np_out = DW'(pmin);
      else                     np_out = DW'(c_np_ff);
      if (bounds_en_ff) begin
         if (np_out < lower_ff) np_out = lower_ff;
         if (np_out > upper_ff) np_out = upper_ff;
      end
   end

   logic    o_valid_ff;
   rsp_type o_rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) o_valid_ff <= 1'b0;
      else       o_valid_ff <= c_valid_ff;
      o_rsp_ff.new_velocity          <= c_nv_ff;
      o_rsp_ff.new_position          <= np_out;
      o_rsp_ff.new_own_best_position <= c_better_ff ? c_req_ff.position
                                                    : c_req_ff.own_best_position;
      o_rsp_ff.new_own_best_fitness  <= c_better_ff ? c_req_ff.fitness
                                                    : c_req_ff.own_best_fitness;
      o_rsp_ff.improved              <= c_better_ff;
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_data  = o_rsp_ff;

endmodule
